/* rtl/radix_text_converter_defines.svh */
// Assertion macros for the radix text converter
`ifndef RADIX_TEXT_CONVERTER_DEFINES_SVH
`define RADIX_TEXT_CONVERTER_DEFINES_SVH

// Check a consequent in the same cycle as the antecedent
`define RTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtc assertion failed");

// Check a consequent in the cycle after the antecedent
`define RTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtc assertion failed");

`endif

/* rtl/rtc_pkg.sv */
`default_nettype none
package rtc_pkg;
  localparam int MAX_RADIX   = 16;
  localparam int VALUE_BITS  = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int STEP_W      = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] REG_SRC_LO    = 3'd0;
  localparam logic [2:0] REG_SRC_HI    = 3'd1;
  localparam logic [2:0] REG_SRC_RADIX = 3'd2;
  localparam logic [2:0] REG_TGT_LO    = 3'd3;
  localparam logic [2:0] REG_TGT_HI    = 3'd4;
  localparam logic [2:0] REG_TGT_RADIX = 3'd5;

  localparam logic [63:0] ALPHA_RESET = 64'd3978425819141910832;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              alphabet_error;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic [RADIX_W-1:0] radix;
  } alpha_cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  function automatic logic [CHAR_W-1:0] alpha_byte(input logic [63:0] lo,
                                                   input logic [63:0] hi,
                                                   input logic [3:0] idx);
    logic [63:0] w;
    w = idx[3] ? hi : lo;
    return w[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic alpha_ok(input alpha_cfg_t a);
    logic ok;
    logic [CHAR_W-1:0] ci;
    ok = (a.radix >= 5'd2) && (a.radix <= 5'(MAX_RADIX));
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < a.radix) begin
        ci = alpha_byte(a.lo, a.hi, 4'(i));
        if (ci == CH_NUL || ci == CH_PLUS || ci == CH_MINUS || is_space(ci)) ok = 1'b0;
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < a.radix && alpha_byte(a.lo, a.hi, 4'(j)) == ci) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction
endpackage
`default_nettype wire

/* rtl/rtc_front.sv */
`default_nettype none
module rtc_front import rtc_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  in_item_t   in_item,
  input  wire        accept,
  input  alpha_cfg_t src,
  output logic       push,
  output job_t       job
);
  logic [1:0]            phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, val;
  logic                  hit;
  logic [DIGIT_W-1:0]    dval;
  logic [RADIX_W-1:0]    n;
  logic [CHAR_W-1:0]     c;

  // Look up the character in the source alphabet, first match wins
  always_comb begin
    c = in_item.in_char;
    n = (src.radix > 5'(MAX_RADIX)) ? 5'(MAX_RADIX) : src.radix;
    hit = 1'b0;
    dval = '0;
    for (int i = 15; i >= 0; i--) begin
      if (5'(i) < n && c != CH_NUL && alpha_byte(src.lo, src.hi, 4'(i)) == c) begin
        hit = 1'b1;
        dval = 4'(i);
      end
    end
  end

  // Advance the parse on each character
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    acc_nxt = acc_r;
    if (phase_r == PH_SPACE && is_space(c)) begin
      phase_nxt = PH_SPACE;
    end else if ((phase_r == PH_SPACE || phase_r == PH_SIGN) &&
                 (c == CH_PLUS || c == CH_MINUS)) begin
      phase_nxt = PH_SIGN;
      if (c == CH_MINUS) neg_nxt = ~neg_r;
    end else if (phase_r != PH_DONE && hit) begin
      phase_nxt = PH_DIGIT;
      acc_nxt = acc_r * VALUE_BITS'(src.radix) + VALUE_BITS'(dval);
    end else begin
      phase_nxt = PH_DONE;
    end
    val = neg_nxt ? (~acc_nxt + 1'b1) : acc_nxt;
    job.neg = val[VALUE_BITS-1];
    job.mag = val[VALUE_BITS-1] ? (~val + 1'b1) : val;
    push = accept && in_item.in_last;
  end

  // Hold parse state, clear it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= PH_SPACE;
      neg_r <= 1'b0;
      acc_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      neg_r <= neg_nxt;
      acc_r <= acc_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/rtc_queue.sv */
`default_nettype none
module rtc_queue import rtc_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  job_t push_job,
  input  wire  pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);
  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule
`default_nettype wire

/* rtl/rtc_back.sv */
`default_nettype none
module rtc_back import rtc_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  job_t       job,
  input  wire        job_avail,
  input  wire        cfg_ok,
  input  alpha_cfg_t tgt,
  output logic       pop,
  output logic       out_valid,
  output out_item_t  out_item
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]            state_r;
  logic [VALUE_BITS-1:0] quo_r, quo_new;
  logic [RADIX_W-1:0]    rem_r, rem_sh, rem_new;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]      n_r;
  logic                  neg_r, ge;
  logic [DIGIT_W-1:0]    store [STORE_DEPTH];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  logic                  wr_en, last_step;

  // One restoring division step per cycle
  always_comb begin
    rem_sh = {rem_r[RADIX_W-2:0], quo_r[VALUE_BITS-1]};
    ge = (rem_sh >= tgt.radix);
    rem_new = ge ? (rem_sh - tgt.radix) : rem_sh;
    quo_new = {quo_r[VALUE_BITS-2:0], ge};
    last_step = (step_r == STEP_W'(VALUE_BITS - 1));
    wr_en = (state_r == S_DIV) && last_step;
    pop = (state_r == S_IDLE) && job_avail;
  end

  // Digit store
  always_ff @(posedge clk) begin
    if (wr_en) store[n_r[ADDR_W-1:0]] <= rem_new[DIGIT_W-1:0];
    if (state_r == S_RD) rd_data_r <= store[ADDR_W'(n_r - 1'b1)];
  end

  // Sequence division and emission
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (!cfg_ok) begin
              out_valid_r <= 1'b1;
              out_item_r <= '{out_char: CH_NUL, out_last: 1'b1, alphabet_error: 1'b1};
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (last_step && (quo_new == '0 || n_r == CNT_W'(STORE_DEPTH - 1))) begin
            state_r <= S_RD;
            if (neg_r) begin
              out_valid_r <= 1'b1;
              out_item_r <= '{out_char: CH_MINUS, out_last: 1'b0, alphabet_error: 1'b0};
            end
          end
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_item_r <= '{out_char: alpha_byte(tgt.lo, tgt.hi, rd_data_r),
                          out_last: (n_r == CNT_W'(1)), alphabet_error: 1'b0};
          state_r <= (n_r == CNT_W'(1)) ? S_IDLE : S_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        quo_r <= job.mag;
        neg_r <= job.neg;
        rem_r <= '0;
        step_r <= '0;
        n_r <= '0;
      end
      S_DIV: begin
        quo_r <= quo_new;
        step_r <= step_r + 1'b1;
        rem_r <= last_step ? '0 : rem_new;
        if (last_step) n_r <= n_r + 1'b1;
      end
      S_OUT: n_r <= n_r - 1'b1;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;
endmodule
`default_nettype wire

/* rtl/radix_text_converter.sv */
// Radix text converter. Characters enter one per cycle while busy is low;
// parsing keeps up with a character every cycle. The character marked last
// hands the value to a two-entry job queue, and busy is high while that queue
// is full. Each job then runs through a bit-serial divider that writes every
// target digit to the digit store, then each digit is read back from the store
// and emitted. Results appear as single-cycle strobes on out_valid and cannot
// be stalled; an invalid alphabet gives one result with alphabet_error set.
`default_nettype none
`include "radix_text_converter_defines.svh"
module radix_text_converter import rtc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  alpha_cfg_t src_r, tgt_r;
  logic       ok_r;
  logic       accept, push, pop, full, empty, wr;
  logic [2:0] idx;
  job_t       push_job, pop_job;

  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;
  assign busy = full;
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '{lo: ALPHA_RESET, hi: '0, radix: RADIX_RESET};
      tgt_r <= '{lo: ALPHA_RESET, hi: '0, radix: RADIX_RESET};
      ok_r <= 1'b1;
    end else begin
      ok_r <= alpha_ok(src_r) && alpha_ok(tgt_r);
      if (wr) begin
        case (idx)
          REG_SRC_LO:    src_r.lo <= pwdata;
          REG_SRC_HI:    src_r.hi <= pwdata;
          REG_SRC_RADIX: src_r.radix <= pwdata[RADIX_W-1:0];
          REG_TGT_LO:    tgt_r.lo <= pwdata;
          REG_TGT_HI:    tgt_r.hi <= pwdata;
          REG_TGT_RADIX: tgt_r.radix <= pwdata[RADIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Read back configuration
  always_comb begin
    case (idx)
      REG_SRC_LO:    prdata = src_r.lo;
      REG_SRC_HI:    prdata = src_r.hi;
      REG_SRC_RADIX: prdata = 64'(src_r.radix);
      REG_TGT_LO:    prdata = tgt_r.lo;
      REG_TGT_HI:    prdata = tgt_r.hi;
      REG_TGT_RADIX: prdata = 64'(tgt_r.radix);
      default:       prdata = '0;
    endcase
  end

  rtc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .accept(accept), .src(src_r),
    .push(push), .job(push_job)
  );

  rtc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .pop_job(pop_job), .full(full), .empty(empty)
  );

  rtc_back u_back (
    .clk(clk), .rst_n(rst_n), .job(pop_job), .job_avail(!empty), .cfg_ok(ok_r),
    .tgt(tgt_r), .pop(pop), .out_valid(out_valid), .out_item(out_item)
  );

  `RTC_ASSERT_SAME(a_err_is_last, out_valid && out_item.alphabet_error, out_item.out_last && out_item.out_char == CH_NUL)
  `RTC_ASSERT_SAME(a_sign_not_last, out_valid && !out_item.alphabet_error && out_item.out_char == CH_MINUS, !out_item.out_last)
  `RTC_ASSERT_NEXT(a_full_blocks, full && !pop, !accept)
endmodule
`default_nettype wire
